// ===== rtl/mbbr_pkg.sv =====
//------------------------------------------------------------------------------
// mbbr_pkg
// Shared types and constants for the monochrome bitmap blit core.
//------------------------------------------------------------------------------
package mbbr_pkg;

   localparam int unsigned COLOR_W   = 16;
   localparam int unsigned COORD_W   = 16;
   localparam int unsigned SPAN_W    = 8;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned LCD_X_W   = 9;
   localparam int unsigned LCD_Y_W   = 8;
   localparam int unsigned CSR_IDX_W = 1;

   localparam int unsigned LCD_OFF_X = 33;
   localparam int unsigned LCD_OFF_Y = 57;

   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_INK   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAPER = 1'b1;

   localparam logic [COLOR_W-1:0] INK_RESET    = 16'h0000;
   localparam logic [COLOR_W-1:0] PAPER_RESET  = 16'hFFFF;
   localparam logic [COLOR_W-1:0] MIRROR_RESET = 16'hFFFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_OR    = 2'd0,
      MODE_AND   = 2'd1,
      MODE_XOR   = 2'd2,
      MODE_COVER = 2'd3
   } rop_mode_type;

   typedef struct packed {
      logic               wr;
      logic [COLOR_W-1:0] color;
   } rop_result_type;

endpackage

// ===== rtl/mbbr_if.sv =====
//------------------------------------------------------------------------------
// mbbr_req_if / mbbr_rsp_if
// Valid/ready channels for blit request words and LCD write words.
//------------------------------------------------------------------------------
interface mbbr_req_if;
   import mbbr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      command;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic [SPAN_W-1:0]         blit_width;
   logic [SPAN_W-1:0]         blit_height;
   logic [MODE_W-1:0]         raster_mode;
   logic                      centered;
   logic [7:0]                bitmap_byte;

   modport source (
      output valid, command, pos_x, pos_y, blit_width, blit_height,
             raster_mode, centered, bitmap_byte,
      input  ready
   );
   modport sink (
      input  valid, command, pos_x, pos_y, blit_width, blit_height,
             raster_mode, centered, bitmap_byte,
      output ready
   );
endinterface

interface mbbr_rsp_if;
   import mbbr_pkg::*;

   logic               valid;
   logic               ready;
   logic [LCD_X_W-1:0] lcd_x;
   logic [LCD_Y_W-1:0] lcd_y;
   logic [COLOR_W-1:0] pixel_color;
   logic               last_write;

   modport source (
      output valid, lcd_x, lcd_y, pixel_color, last_write,
      input  ready
   );
   modport sink (
      input  valid, lcd_x, lcd_y, pixel_color, last_write,
      output ready
   );
endinterface

// ===== rtl/mono_bitmap_blit_rop_core.sv =====
//------------------------------------------------------------------------------
// mono_bitmap_blit_rop_core
// Bitmap blit with raster ops onto a color mirror of the logical screen,
// emitting 2x2 doubled LCD pixel writes.
//
//   channel   dir  handshake          word
//   req_bus   in   valid/ready        begin geometry or one bitmap byte
//   rsp_bus   out  valid/ready        one LCD pixel write
//   csr_*     in   csr_we, no ready   ink/paper color
//
// A data word walks its bits MSB first through a shift register, one pixel
// per step. The registered read of the screen mirror sets the per-pixel
// pace. After reset a clearing pass writes all SCREEN_WIDTH*SCREEN_HEIGHT
// mirror entries (8192 by default) before the first word is taken. A
// stalled rsp_bus holds the current write and the walk.
//------------------------------------------------------------------------------
module mono_bitmap_blit_rop_core #(
   parameter int unsigned SCREEN_WIDTH  = 128,
   parameter int unsigned SCREEN_HEIGHT = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   mbbr_req_if.sink                          req_bus,
   mbbr_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [mbbr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbbr_pkg::COLOR_W-1:0]      csr_wdata
);
   import mbbr_pkg::*;

   localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned XW    = $clog2(SCREEN_WIDTH);
   localparam int unsigned YW    = $clog2(SCREEN_HEIGHT);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_PIX    = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_EMIT   = 6'b010000,
      ST_ADV    = 6'b100000
   } state_type;

   state_type          state_ff,      state_in;
   logic [AW-1:0]      clr_addr_ff,   clr_addr_in;
   logic [COLOR_W-1:0] ink_ff,        ink_in;
   logic [COLOR_W-1:0] paper_ff,      paper_in;
   logic [COORD_W-1:0] org_x_ff,      org_x_in;
   logic [COORD_W-1:0] org_y_ff,      org_y_in;
   logic [SPAN_W-1:0]  span_w_ff,     span_w_in;
   logic [SPAN_W-1:0]  span_h_ff,     span_h_in;
   rop_mode_type       mode_ff,       mode_in;
   logic [SPAN_W-1:0]  cur_x_ff,      cur_x_in;
   logic [SPAN_W-1:0]  cur_y_ff,      cur_y_in;
   logic [7:0]         shift_ff,      shift_in;
   logic [2:0]         bit_cnt_ff,    bit_cnt_in;
   logic [XW-1:0]      pix_x_ff,      pix_x_in;
   logic [YW-1:0]      pix_y_ff,      pix_y_in;
   logic [AW-1:0]      wr_addr_ff,    wr_addr_in;
   logic [COLOR_W-1:0] cand_color_ff, cand_color_in;
   logic [XW-1:0]      pend_x_ff,     pend_x_in;
   logic [YW-1:0]      pend_y_ff,     pend_y_in;
   logic [COLOR_W-1:0] pend_color_ff, pend_color_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               emit_last_ff,  emit_last_in;
   logic [1:0]         sub_ff,        sub_in;

   logic [COLOR_W-1:0] mirror [DEPTH];
   logic [COLOR_W-1:0] mem_q_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [COLOR_W-1:0] mem_wd;
   logic [AW-1:0]      pix_addr;

   logic [COORD_W-1:0] sum_x;
   logic [COORD_W-1:0] sum_y;
   logic               on_screen;
   logic               req_fire;
   logic               rsp_fire;
   logic               row_end;
   rop_result_type     rop;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   assign sum_x     = org_x_ff + COORD_W'(cur_x_ff);
   assign sum_y     = org_y_ff + COORD_W'(cur_y_ff);
   assign on_screen = !sum_x[COORD_W-1] && (sum_x < COORD_W'(SCREEN_WIDTH)) &&
                      !sum_y[COORD_W-1] && (sum_y < COORD_W'(SCREEN_HEIGHT));
   assign pix_addr  = AW'(AW'(sum_y[YW-1:0]) * AW'(SCREEN_WIDTH)) + AW'(sum_x[XW-1:0]);
   assign row_end   = ({1'b0, cur_x_ff} + 9'd1) >= {1'b0, span_w_ff};

   mbbr_rop u_rop (
      .pix_set (shift_ff[7]),
      .mode    (mode_ff),
      .stored  (mem_q_ff),
      .ink     (ink_ff),
      .paper   (paper_ff),
      .result  (rop)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = (state_ff == ST_EMIT);
   assign rsp_bus.pixel_color = pend_color_ff;
   assign rsp_bus.last_write  = emit_last_ff && (sub_ff == 2'd3);
   assign rsp_bus.lcd_x = (LCD_X_W'(pend_x_ff) << 1) + LCD_X_W'(LCD_OFF_X) +
                          LCD_X_W'(sub_ff[0]);
   assign rsp_bus.lcd_y = (LCD_Y_W'(pend_y_ff) << 1) + LCD_Y_W'(LCD_OFF_Y) +
                          LCD_Y_W'(sub_ff[1]);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      ink_in        = ink_ff;
      paper_in      = paper_ff;
      org_x_in      = org_x_ff;
      org_y_in      = org_y_ff;
      span_w_in     = span_w_ff;
      span_h_in     = span_h_ff;
      mode_in       = mode_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      shift_in      = shift_ff;
      bit_cnt_in    = bit_cnt_ff;
      pix_x_in      = pix_x_ff;
      pix_y_in      = pix_y_ff;
      wr_addr_in    = wr_addr_ff;
      cand_color_in = cand_color_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_color_in = pend_color_ff;
      pend_valid_in = pend_valid_ff;
      emit_last_in  = emit_last_ff;
      sub_in        = sub_ff;
      mem_we        = 1'b0;
      mem_wa        = wr_addr_ff;
      mem_wd        = rop.color;

      if (csr_we) begin
         case (csr_index)
            CSR_INK:   ink_in   = csr_wdata;
            CSR_PAPER: paper_in = csr_wdata;
            default:   ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            mem_wd      = MIRROR_RESET;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.command == CMD_BEGIN) begin
                  span_w_in = req_bus.blit_width;
                  span_h_in = req_bus.blit_height;
                  mode_in   = rop_mode_type'(req_bus.raster_mode);
                  cur_x_in  = '0;
                  cur_y_in  = '0;
                  if (req_bus.centered) begin
                     org_x_in = req_bus.pos_x - COORD_W'(req_bus.blit_width >> 1);
                     org_y_in = req_bus.pos_y - COORD_W'(req_bus.blit_height >> 1);
                  end else begin
                     org_x_in = req_bus.pos_x;
                     org_y_in = req_bus.pos_y;
                  end
               end else if ((span_w_ff != '0) && (cur_y_ff < span_h_ff)) begin
                  shift_in   = req_bus.bitmap_byte;
                  bit_cnt_in = '0;
                  state_in   = ST_PIX;
               end
            end
         end
         ST_PIX: begin
            pix_x_in   = sum_x[XW-1:0];
            pix_y_in   = sum_y[YW-1:0];
            wr_addr_in = pix_addr;
            state_in   = on_screen ? ST_DECIDE : ST_ADV;
         end
         ST_DECIDE: begin
            if (rop.wr) begin
               mem_we        = 1'b1;
               cand_color_in = rop.color;
               if (pend_valid_ff) begin
                  emit_last_in = 1'b0;
                  state_in     = ST_EMIT;
               end else begin
                  pend_x_in     = pix_x_ff;
                  pend_y_in     = pix_y_ff;
                  pend_color_in = rop.color;
                  pend_valid_in = 1'b1;
                  state_in      = ST_ADV;
               end
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               sub_in = sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  if (emit_last_ff) begin
                     pend_valid_in = 1'b0;
                     state_in      = ST_IDLE;
                  end else begin
                     // queued pixel moves up behind the one just sent
                     pend_x_in     = pix_x_ff;
                     pend_y_in     = pix_y_ff;
                     pend_color_in = cand_color_ff;
                     state_in      = ST_ADV;
                  end
               end
            end
         end
         ST_ADV: begin
            shift_in   = shift_ff << 1;
            bit_cnt_in = bit_cnt_ff + 3'd1;
            if (row_end) begin
               cur_x_in = '0;
               cur_y_in = cur_y_ff + 1'b1;
            end else begin
               cur_x_in = cur_x_ff + 1'b1;
            end
            if (row_end || (bit_cnt_ff == 3'd7)) begin
               if (pend_valid_ff) begin
                  emit_last_in = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_PIX;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mirror[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mirror[pix_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         ink_ff        <= INK_RESET;
         paper_ff      <= PAPER_RESET;
         org_x_ff      <= '0;
         org_y_ff      <= '0;
         span_w_ff     <= '0;
         span_h_ff     <= '0;
         mode_ff       <= MODE_OR;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         pend_valid_ff <= 1'b0;
         emit_last_ff  <= 1'b0;
         sub_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         ink_ff        <= ink_in;
         paper_ff      <= paper_in;
         org_x_ff      <= org_x_in;
         org_y_ff      <= org_y_in;
         span_w_ff     <= span_w_in;
         span_h_ff     <= span_h_in;
         mode_ff       <= mode_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         pend_valid_ff <= pend_valid_in;
         emit_last_ff  <= emit_last_in;
         sub_ff        <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      bit_cnt_ff    <= bit_cnt_in;
      pix_x_ff      <= pix_x_in;
      pix_y_ff      <= pix_y_in;
      wr_addr_ff    <= wr_addr_in;
      cand_color_ff <= cand_color_in;
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
      pend_color_ff <= pend_color_in;
   end

   a_clear_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (state_ff == ST_CLEAR))
      else $error("clearing pass not started after reset");

   a_no_pending_on_accept : assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !pend_valid_ff)
      else $error("word accepted with a pixel write still pending");

   a_last_returns_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_bus.last_write) |=> (state_ff == ST_IDLE))
      else $error("final write of a word not followed by idle");

endmodule

// ===== rtl/mbbr_rop.sv =====
//------------------------------------------------------------------------------
// mbbr_rop
// Raster operation for one pixel: compares the stored color against ink and
// paper and decides whether and what to write.
//------------------------------------------------------------------------------
module mbbr_rop (
   input  logic                            pix_set,
   input  mbbr_pkg::rop_mode_type          mode,
   input  logic [mbbr_pkg::COLOR_W-1:0]    stored,
   input  logic [mbbr_pkg::COLOR_W-1:0]    ink,
   input  logic [mbbr_pkg::COLOR_W-1:0]    paper,
   output mbbr_pkg::rop_result_type        result
);
   import mbbr_pkg::*;

   logic hit_paper;
   logic hit_ink;

   assign hit_paper = (stored == paper);
   assign hit_ink   = (stored == ink);

   always_comb begin
      result.wr    = 1'b0;
      result.color = ink;
      if (pix_set) begin
         if (hit_paper && (mode != MODE_AND)) begin
            result.wr    = 1'b1;
            result.color = ink;
         end else if (hit_ink && (mode == MODE_XOR)) begin
            result.wr    = 1'b1;
            result.color = paper;
         end
      end else if (hit_ink && ((mode == MODE_AND) || (mode == MODE_COVER))) begin
         result.wr    = 1'b1;
         result.color = paper;
      end
   end

endmodule
